@@ hw/rtl/matrix_multiply_macros.svh @@
// assertion macros for the matrix multiply block
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS
`define MM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("matrix_multiply assertion failed");
`define MM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("matrix_multiply forbidden condition seen");
`else
`define MM_ASSERT(lbl, clk, rstn, prop)
`define MM_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ hw/rtl/mm_pkg.sv @@
`default_nettype none

package mm_pkg;

  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned ACC_W     = 35;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                     wr_a;
    logic                     wr_b;
    logic [IDX_W-1:0]         wr_row;
    logic [IDX_W-1:0]         wr_col;
    logic signed [ELEM_W-1:0] wr_value;
    logic                     rd;
    logic                     first;
    logic                     last_dot;
    logic                     last_elem;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic [IDX_W-1:0]         k_idx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/mm_in_if.sv @@
`default_nettype none

interface mm_in_if import mm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [ELEM_W-1:0] value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink (input valid, input mode, input row, input col, input value,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mm_out_if.sv @@
`default_nettype none

interface mm_out_if import mm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_value;
  logic                    last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mm_ram.sv @@
`default_nettype none

module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/mm_ctrl.sv @@
`default_nettype none

module mm_ctrl import mm_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  mm_in_if.sink                     in_i,
  input  wire status_t              status_i,
  output cmd_t                      cmd_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CW    = IDX_W + 1;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_e;

  state_e           state_q;
  logic [DIM_W-1:0] h_q, k_q, w_q;
  logic [IDX_W-1:0] y_q, x_q, i_q;
  cmd_t             cmd_q;

  logic go, last_i, last_x, last_y, in_range;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > CFG_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v[DIM_W-1:0];
  endfunction

  assign last_i   = (CW'(i_q) + CW'(1)) == CW'(k_q);
  assign last_x   = (CW'(x_q) + CW'(1)) == CW'(w_q);
  assign last_y   = (CW'(y_q) + CW'(1)) == CW'(h_q);
  assign go       = (i_q != '0) || (!status_i.busy && !status_i.out_valid);
  assign in_range = (CW'(in_i.row) < CW'(MAX_DIM)) && (CW'(in_i.col) < CW'(MAX_DIM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q     <= DIM_W'(MAX_DIM);
      k_q     <= DIM_W'(MAX_DIM);
      w_q     <= DIM_W'(MAX_DIM);
      y_q     <= '0;
      x_q     <= '0;
      i_q     <= '0;
      cmd_q   <= '0;
    end else begin
      cmd_q.wr_a <= 1'b0;
      cmd_q.wr_b <= 1'b0;
      cmd_q.rd   <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ROWS_A:    h_q <= clamp_dim(cfg_data_i);
          CFG_INNER_LEN: k_q <= clamp_dim(cfg_data_i);
          CFG_COLS_B:    w_q <= clamp_dim(cfg_data_i);
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            cmd_q.wr_row   <= in_i.row;
            cmd_q.wr_col   <= in_i.col;
            cmd_q.wr_value <= in_i.value;
            unique case (mode_e'(in_i.mode))
              MODE_LOAD_A: cmd_q.wr_a <= in_range;
              MODE_LOAD_B: cmd_q.wr_b <= in_range;
              MODE_COMPUTE: begin
                y_q     <= '0;
                x_q     <= '0;
                i_q     <= '0;
                state_q <= ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          if (go) begin
            cmd_q.rd        <= 1'b1;
            cmd_q.first     <= (i_q == '0);
            cmd_q.last_dot  <= last_i;
            cmd_q.last_elem <= last_i && last_x && last_y;
            cmd_q.out_row   <= y_q;
            cmd_q.out_col   <= x_q;
            cmd_q.k_idx     <= i_q;
            if (last_i) begin
              i_q <= '0;
              if (last_x) begin
                x_q <= '0;
                if (last_y) begin
                  state_q <= ST_IDLE;
                end else begin
                  y_q <= y_q + IDX_W'(1);
                end
              end else begin
                x_q <= x_q + IDX_W'(1);
              end
            end else begin
              i_q <= i_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign cmd_o      = cmd_q;

endmodule

`default_nettype wire

@@ hw/rtl/mm_dp.sv @@
`default_nettype none

module mm_dp import mm_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  output status_t    status_o,
  mm_out_if.source   out_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = 2 * IDX_W + 1;

  logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0] a_data, b_data;

  logic s1_valid_q, s1_first_q, s1_last_dot_q, s1_last_elem_q;
  logic [IDX_W-1:0] s1_row_q, s1_col_q;
  logic s2_valid_q, s2_first_q, s2_last_dot_q, s2_last_elem_q;
  logic [IDX_W-1:0] s2_row_q, s2_col_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, sum;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [ACC_W-1:0] out_value_q;
  logic                    out_last_q;

  function automatic logic [AW-1:0] elem_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [XW-1:0] full;
    full = XW'(r) * XW'(MAX_DIM) + XW'(c);
    return full[AW-1:0];
  endfunction

  assign wr_addr   = elem_addr(cmd_i.wr_row, cmd_i.wr_col);
  assign rd_addr_a = elem_addr(cmd_i.out_row, cmd_i.k_idx);
  assign rd_addr_b = elem_addr(cmd_i.k_idx, cmd_i.out_col);

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_a),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_i.wr_value),
    .rd_en_i   (cmd_i.rd),
    .rd_addr_i (rd_addr_a),
    .rd_data_o (a_data)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_b),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_i.wr_value),
    .rd_en_i   (cmd_i.rd),
    .rd_addr_i (rd_addr_b),
    .rd_data_o (b_data)
  );

  assign sum = s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q && s2_last_dot_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q     <= cmd_i.first;
    s1_last_dot_q  <= cmd_i.last_dot;
    s1_last_elem_q <= cmd_i.last_elem;
    s1_row_q       <= cmd_i.out_row;
    s1_col_q       <= cmd_i.out_col;
    s2_first_q     <= s1_first_q;
    s2_last_dot_q  <= s1_last_dot_q;
    s2_last_elem_q <= s1_last_elem_q;
    s2_row_q       <= s1_row_q;
    s2_col_q       <= s1_col_q;
    prod_q         <= $signed(a_data) * $signed(b_data);
    if (s2_valid_q) begin
      acc_q <= sum;
      if (s2_last_dot_q) begin
        out_row_q   <= s2_row_q;
        out_col_q   <= s2_col_q;
        out_value_q <= sum;
        out_last_q  <= s2_last_elem_q;
      end
    end
  end

  assign status_o.busy      = cmd_i.rd | s1_valid_q | s2_valid_q;
  assign status_o.out_valid = out_valid_q;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/matrix_multiply.sv @@
// load items: one per cycle while idle, no result, written to the element store on the next edge
// compute item: rows_a*cols_b results, one multiply-accumulate per cycle within a c element
// (the next element starts only after the read, multiply and accumulate stages drain
// and the output register has emptied)
// reset: sizes return to MAX_DIM (8 by default), control cleared, stores undefined until written
`default_nettype none
`include "matrix_multiply_macros.svh"

module matrix_multiply import mm_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  mm_in_if.sink                     in_i,
  mm_out_if.source                  out_o
);

  cmd_t    cmd;
  status_t status;
  logic    compute_acc;

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

  assign compute_acc = in_i.valid && in_i.ready && (in_i.mode == MODE_COMPUTE);

  `MM_ASSERT(a_compute_drops_ready, clk_i, rst_ni, compute_acc |=> !in_i.ready)
  `MM_NEVER(a_no_read_write_overlap, clk_i, rst_ni, cmd.rd && (cmd.wr_a || cmd.wr_b))
  `MM_ASSERT(a_first_issue_out_free, clk_i, rst_ni, (cmd.rd && cmd.first) |-> !status.out_valid)

endmodule

`default_nettype wire
